FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SATD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SATD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/satd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satd_pkg
// Types, codes and defaults shared by the sorted account table.
// ----------------------------------------------------------------------------
package satd_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned KEY_W       = 30;
  localparam int unsigned AMT_W       = 32;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_DEBIT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_APPROVED     = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_INSUFFICIENT = 3'd2,
    ST_LOADED       = 3'd3,
    ST_FULL         = 3'd4,
    ST_DUPLICATE    = 3'd5
  } status_e;

  typedef struct packed {
    op_e              cmd;
    logic [KEY_W-1:0] account_key;
    logic [AMT_W-1:0] amount;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [AMT_W-1:0] balance_out;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] balance;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_COMPARE,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESPOND
  } ctrl_state_e;

  typedef struct packed {
    logic    capture;
    logic    probe_rd;
    logic    probe_cmp;
    logic    shift_init;
    logic    shift_rd;
    logic    shift_wr;
    logic    insert_wr;
    logic    debit_wr;
    logic    set_status;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic search_done;
    logic is_load;
    logic hit;
    logic full;
    logic funds_ok;
    logic shift_done;
  } dp_stat_t;

endpackage

FILE: rtl/satd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satd_ctrl
// Sequencer for search, insert shift, debit write-back and result beat.
// ----------------------------------------------------------------------------
module satd_ctrl import satd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = ST_APPROVED;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat_i.search_done) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.probe_rd = 1'b1;
          state_d        = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd_o.probe_cmp = 1'b1;
        state_d         = S_PROBE;
      end
      S_DECIDE: begin
        state_d          = S_RESPOND;
        cmd_o.set_status = 1'b1;
        if (stat_i.is_load) begin
          if (stat_i.hit) begin
            cmd_o.status = ST_DUPLICATE;
          end else if (stat_i.full) begin
            cmd_o.status = ST_FULL;
          end else begin
            cmd_o.set_status = 1'b0;
            cmd_o.shift_init = 1'b1;
            state_d          = S_SHIFT_RD;
          end
        end else begin
          if (!stat_i.hit) begin
            cmd_o.status = ST_NOT_FOUND;
          end else if (stat_i.funds_ok) begin
            cmd_o.status   = ST_APPROVED;
            cmd_o.debit_wr = 1'b1;
          end else begin
            cmd_o.status = ST_INSUFFICIENT;
          end
        end
      end
      S_SHIFT_RD: begin
        if (stat_i.shift_done) begin
          cmd_o.insert_wr  = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_LOADED;
          state_d          = S_RESPOND;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      S_RESPOND: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/satd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satd_dp
// Entry memory, search bounds, shift pointer, entry count and result register.
// ----------------------------------------------------------------------------
module satd_dp import satd_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  req_t     req_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output rsp_t     rsp_o
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned IDX_W = $clog2(ENTRIES);

  entry_t mem [ENTRIES];
  entry_t rdata_q;

  req_t             req_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             hit_q, hit_d;
  logic [AMT_W-1:0] hit_bal_q, hit_bal_d;
  status_e          status_q;
  logic [AMT_W-1:0] bal_q;

  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] ptr_dec;
  logic [AMT_W:0]   diff;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign ptr_dec = ptr_q - CNT_W'(1);
  assign diff    = {1'b0, hit_bal_q} - {1'b0, req_q.amount};

  assign stat_o.search_done = (lo_q >= hi_q);
  assign stat_o.is_load     = (req_q.cmd == OP_LOAD);
  assign stat_o.hit         = hit_q;
  assign stat_o.full        = (count_q == CNT_W'(ENTRIES));
  assign stat_o.funds_ok    = ~diff[AMT_W];
  assign stat_o.shift_done  = (ptr_q <= lo_q);

  always_comb begin
    rd_en   = cmd_i.probe_rd | cmd_i.shift_rd;
    rd_addr = cmd_i.shift_rd ? ptr_dec[IDX_W-1:0] : mid[IDX_W-1:0];
    wr_en   = cmd_i.shift_wr | cmd_i.insert_wr | cmd_i.debit_wr;
    wr_addr = cmd_i.shift_wr ? ptr_q[IDX_W-1:0] : lo_q[IDX_W-1:0];
    priority if (cmd_i.shift_wr) begin
      wr_data = rdata_q;
    end else if (cmd_i.insert_wr) begin
      wr_data = '{key: req_q.account_key, balance: req_q.amount};
    end else begin
      wr_data = '{key: req_q.account_key, balance: diff[AMT_W-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    lo_d      = lo_q;
    hi_d      = hi_q;
    ptr_d     = ptr_q;
    hit_d     = hit_q;
    hit_bal_d = hit_bal_q;
    count_d   = count_q;
    if (cmd_i.capture) begin
      lo_d  = '0;
      hi_d  = count_q;
      hit_d = 1'b0;
    end
    if (cmd_i.probe_cmp) begin
      if (rdata_q.key < req_q.account_key) begin
        lo_d = mid + CNT_W'(1);
      end else begin
        hi_d = mid;
      end
      if (rdata_q.key == req_q.account_key) begin
        hit_d     = 1'b1;
        hit_bal_d = rdata_q.balance;
      end
    end
    if (cmd_i.shift_init) begin
      ptr_d = count_q;
    end
    if (cmd_i.shift_wr) begin
      ptr_d = ptr_dec;
    end
    if (cmd_i.insert_wr) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      ptr_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      ptr_q   <= ptr_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_bal_q <= hit_bal_d;
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
      bal_q    <= (cmd_i.status == ST_APPROVED) ? diff[AMT_W-1:0] : req_q.amount;
    end
  end

  assign rsp_o.status      = status_q;
  assign rsp_o.balance_out = bal_q;

endmodule

FILE: rtl/sorted_account_table_debit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_account_table_debit
// Sorted key table with load-insert and debit lookup, one result per request.
// ----------------------------------------------------------------------------
//  channel  | ports           | handshake                    | payload
//  request  | start, busy     | beat when start && !busy     | req_i  (req_t)
//  result   | done_o          | one-cycle strobe, no stall   | rsp_o  (rsp_t)
//
//  A debit holds busy through p binary search probes (p up to
//  ceil(log2(count+1))), each a registered read then a compare, then the
//  decide step and the result beat. A load that inserts also moves every
//  entry above its slot up by one place, each by a read then a write, and
//  then writes the new entry; the entry memory has a registered read.
//  Reset empties the table at once (entry count to zero); no clearing pass.
//  done_o falls in the last busy cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module sorted_account_table_debit import satd_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  satd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (dp_stat),
    .cmd_o   (dp_cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  satd_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (dp_cmd),
    .stat_o (dp_stat),
    .rsp_o  (rsp_o)
  );

endmodule

FILE: rtl/satd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satd_checker
// Port-level checks on the request and result beats of the account table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module satd_checker import satd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input rsp_t rsp_o
);

  logic rsp_known;

  assign rsp_known = ~$isunknown(rsp_o.status);

  `SATD_ASSERT_NOW(a_done_busy, clk_i, rst_ni, done_o, busy && rsp_known, "result outside busy")
  `SATD_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy, "busy after result beat")
  `SATD_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "result strobe repeated")
  `SATD_ASSERT_NEXT(a_accept, clk_i, rst_ni, start && !busy, busy && !done_o, "request beat lost")

endmodule

bind sorted_account_table_debit satd_checker u_satd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

FILE: tb/sorted_account_table_debit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_account_table_debit_tb
// Self-checking bench for the sorted account table with load and debit.
// Loads and debits are driven through the start/busy command port. A ledger
// class mirrors the sorted table, works out the status and balance of each
// accepted beat, and checks every done_o strobe against the oldest pending
// reply. Directed beats hit the empty, duplicate, full, zero and extreme cases.
// Random beats then mix debits on held accounts with misses and refused loads.
// ----------------------------------------------------------------------------
module sorted_account_table_debit_tb;
  import satd_pkg::*;

  localparam int unsigned     IDLE_LIMIT = 2000;
  localparam int unsigned     RANDOM_BEATS = 400;
  localparam logic [KEY_W-1:0] KEY_TOP = '1;
  localparam logic [KEY_W-1:0] KEY_NINE = 30'd999999999;
  localparam logic [KEY_W-1:0] KEY_MID = 30'd500000000;
  localparam logic [AMT_W-1:0] AMT_TOP = '1;

  class account_ledger;
    logic [KEY_W-1:0] keys [ENTRIES_DEF];
    logic [AMT_W-1:0] funds [ENTRIES_DEF];
    int unsigned      fill;
    rsp_t             replies_due [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      tally [6];

    function new();
      fill = 0;
      errors = 0;
      checked = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function int slot_of(logic [KEY_W-1:0] k);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = fill;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (keys[mid] < k) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function logic [AMT_W-1:0] balance_of(logic [KEY_W-1:0] k);
      int pos;
      pos = slot_of(k);
      if (pos < int'(fill) && keys[pos] == k) return funds[pos];
      return '0;
    endfunction

    function rsp_t settle(req_t r);
      rsp_t o;
      int   pos;
      bit   hit;
      o.status = ST_APPROVED;
      o.balance_out = r.amount;
      pos = slot_of(r.account_key);
      hit = (pos < int'(fill)) && (keys[pos] == r.account_key);
      if (r.cmd == OP_LOAD) begin
        if (hit) begin
          o.status = ST_DUPLICATE;
        end else if (fill >= ENTRIES_DEF) begin
          o.status = ST_FULL;
        end else begin
          for (int i = int'(fill); i > pos; i--) begin
            keys[i] = keys[i-1];
            funds[i] = funds[i-1];
          end
          keys[pos] = r.account_key;
          funds[pos] = r.amount;
          fill++;
          o.status = ST_LOADED;
        end
      end else begin
        if (!hit) begin
          o.status = ST_NOT_FOUND;
        end else if (funds[pos] >= r.amount) begin
          funds[pos] = funds[pos] - r.amount;
          o.balance_out = funds[pos];
        end else begin
          o.status = ST_INSUFFICIENT;
        end
      end
      return o;
    endfunction

    function void note_request(req_t r);
      replies_due.push_back(settle(r));
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    task check_reply(rsp_t got);
      rsp_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("reply %s/%0d with no request pending",
                         got.status.name(), got.balance_out));
      end else begin
        want = replies_due.pop_front();
        checked++;
        tally[int'(want.status)]++;
        if (got.status !== want.status)
          report($sformatf("reply %0d status %0d, want %s", checked,
                           got.status, want.status.name()));
        if (got.balance_out !== want.balance_out)
          report($sformatf("reply %0d balance_out %0d, want %0d", checked,
                           got.balance_out, want.balance_out));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;

  account_ledger board;
  int unsigned   calm_left = 0;
  int unsigned   idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  sorted_account_table_debit #(
    .ENTRIES (ENTRIES_DEF)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) board.check_reply(rsp_o);
      if (start && !busy) board.note_request(req_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] timeout: no beat for %0d cycles, %0d replies pending",
               $realtime, idle_cycles, board.replies_due.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function int unsigned pick_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      calm_left = $urandom_range(40, 10);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function req_t make_req(op_e c, logic [KEY_W-1:0] k, logic [AMT_W-1:0] a);
    req_t r;
    r.cmd = c;
    r.account_key = k;
    r.amount = a;
    return r;
  endfunction

  // hold start high until the beat is taken
  task automatic post_request(req_t item);
    int unsigned gap;
    logic [63:0] junk;
    gap = pick_gap();
    if (gap != 0) begin
      junk = {$urandom, $urandom};
      start <= 1'b0;
      req_i <= junk[$bits(req_t)-1:0];
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy);
  endtask

  function req_t random_request();
    logic [KEY_W-1:0] k;
    logic [AMT_W-1:0] bal;
    logic [AMT_W-1:0] a;
    int unsigned      r;
    r = $urandom_range(99);
    k = board.keys[$urandom_range(board.fill - 1)];
    if (r < 60) begin
      bal = board.balance_of(k);
      case ($urandom_range(9))
        0, 1: a = bal;
        2: a = bal + 1'b1;
        3: a = '0;
        4, 5: a = $urandom_range(1000, 1);
        6: a = bal >> 1;
        7, 8: a = $urandom;
        default: a = AMT_TOP;
      endcase
      return make_req(OP_DEBIT, k, a);
    end
    if (r < 66) return make_req(OP_DEBIT, k + 1'b1, $urandom);
    if (r < 72) return make_req(OP_DEBIT, k - 1'b1, $urandom);
    if (r < 80) return make_req(OP_DEBIT, KEY_W'($urandom), $urandom);
    if (r < 90) return make_req(OP_LOAD, k, $urandom);
    return make_req(OP_LOAD, KEY_W'($urandom), $urandom);
  endfunction

  initial begin
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    post_request(make_req(OP_DEBIT, '0, '0));
    post_request(make_req(OP_LOAD, KEY_MID, 32'd1000));
    post_request(make_req(OP_LOAD, KEY_TOP, AMT_TOP));
    post_request(make_req(OP_LOAD, KEY_NINE, 32'd12345));
    post_request(make_req(OP_LOAD, KEY_MID, 32'd7));
    post_request(make_req(OP_DEBIT, KEY_MID, '0));
    post_request(make_req(OP_DEBIT, KEY_MID, 32'd1000));
    post_request(make_req(OP_DEBIT, KEY_MID, 32'd1));
    post_request(make_req(OP_DEBIT, KEY_TOP, AMT_TOP));
    post_request(make_req(OP_DEBIT, KEY_NINE, AMT_TOP));
    post_request(make_req(OP_DEBIT, 30'd123, 32'd5));
    repeat (ENTRIES_DEF - 4)
      post_request(make_req(OP_LOAD, KEY_W'($urandom_range(KEY_TOP - 1, 1)), $urandom));
    post_request(make_req(OP_LOAD, '0, '0));
    post_request(make_req(OP_LOAD, 30'd77, 32'd77));
    post_request(make_req(OP_LOAD, KEY_NINE, '0));
    post_request(make_req(OP_DEBIT, '0, '0));
    post_request(make_req(OP_DEBIT, '0, 32'd1));

    repeat (RANDOM_BEATS) post_request(random_request());
    start <= 1'b0;

    while (board.replies_due.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (board.replies_due.size() != 0)
      board.report($sformatf("%0d replies never arrived", board.replies_due.size()));

    $display("Checked %0d replies against the mirrored table, %0d mismatches.",
             board.checked, board.errors);
    $display("Outcomes: approved %0d, not found %0d, insufficient %0d,",
             board.tally[ST_APPROVED], board.tally[ST_NOT_FOUND],
             board.tally[ST_INSUFFICIENT]);
    $display("  loaded %0d, full %0d, duplicate %0d.",
             board.tally[ST_LOADED], board.tally[ST_FULL], board.tally[ST_DUPLICATE]);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
